### hw/rtl/eea_pkg.sv
package eea_pkg;

   localparam int DataW  = 36;
   localparam int PhaseW = 34;
   localparam int TurnW  = 32;
   localparam int MaxStages = 24;

   typedef logic signed [DataW-1:0]  data_type;
   typedef logic signed [PhaseW-1:0] phase_type;
   typedef logic [TurnW-1:0]         turn_type;

   typedef enum logic [0:0] {
      REG_INCIDENCE = 1'b0,
      REG_TILT      = 1'b1
   } csr_index_type;

   localparam turn_type QuarterTurn = 32'h4000_0000;
   localparam turn_type HalfTurn    = 32'h8000_0000;
   localparam data_type OneQ30      = 36'sd1073741824;

   // Arctangent of 2^-i in units where 2^32 is one full turn.
   localparam longint AtanTab [MaxStages] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
   };

   // Inverse CORDIC gain in Q30 for a given number of iterations.
   function automatic int gain_kq(input int n);
      longint t;
      t = (longint'(434688583) + (longint'(1) <<< (2 * n - 1))) >>> (2 * n);
      return int'(longint'(652032874) + t);
   endfunction

endpackage

### hw/rtl/eea_req_if.sv
interface eea_req_if #(parameter int ANGLE_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] polar_angle;
   logic [ANGLE_BITS-1:0] azimuth_angle;

   modport source (output valid, output polar_angle, output azimuth_angle, input ready);
   modport sink (input valid, input polar_angle, input azimuth_angle, output ready);
endinterface

### hw/rtl/eea_rsp_if.sv
interface eea_rsp_if #(parameter int ANGLE_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] exit_angle;

   modport source (output valid, output exit_angle, input ready);
   modport sink (input valid, input exit_angle, output ready);
endinterface

### hw/rtl/eea_gain.sv
module eea_gain #(
   parameter int KQ = 652032874
) (
   input  logic              clock,
   input  logic              en,
   input  eea_pkg::data_type in_v,
   output eea_pkg::data_type out_v
);
   localparam int LoW = 18;
   localparam int HiW = eea_pkg::DataW - LoW;
   localparam int ProdW = 50;
   localparam int SumW = 68;
   localparam logic signed [31:0] KqS = 32'(KQ);

   logic signed [HiW-1:0]   v_hi;
   logic signed [LoW:0]     v_lo;
   logic signed [ProdW-1:0] p_hi_in, p_hi_ff, p_lo_in, p_lo_ff;
   logic signed [SumW-1:0]  sum;

   // The product is split in two partial products so that no multiplier
   // exceeds about 19 by 32 bits; they are summed in the next stage.
   assign v_hi = HiW'(in_v >>> LoW);
   assign v_lo = $signed({1'b0, in_v[LoW-1:0]});
   assign p_hi_in = ProdW'(v_hi) * ProdW'(KqS);
   assign p_lo_in = ProdW'(v_lo) * ProdW'(KqS);

   always_ff @(posedge clock) begin
      if (en) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
      end
   end

   assign sum = (SumW'(p_hi_ff) <<< LoW) + SumW'(p_lo_ff) + (SumW'(1) <<< 29);

   always_ff @(posedge clock) begin
      if (en) begin
         out_v <= eea_pkg::DataW'(sum >>> 30);
      end
   end
endmodule

### hw/rtl/eea_rot.sv
module eea_rot #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 16,
   parameter int KQ     = 652032874
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  eea_pkg::data_type in_a,
   input  eea_pkg::data_type in_b,
   input  eea_pkg::turn_type in_phase,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output eea_pkg::data_type out_a,
   output eea_pkg::data_type out_b,
   output logic [SIDE_W-1:0] out_side
);
   localparam int Last = STAGES + 2;

   logic               v_ff    [0:Last];
   logic               byp_ff  [0:Last];
   eea_pkg::data_type  oa_ff   [0:Last];
   eea_pkg::data_type  ob_ff   [0:Last];
   logic [SIDE_W-1:0]  side_ff [0:Last];
   eea_pkg::data_type  x_ff    [0:STAGES];
   eea_pkg::data_type  y_ff    [0:STAGES];
   eea_pkg::phase_type z_ff    [0:STAGES];

   logic              fold;
   eea_pkg::turn_type p_fold;
   eea_pkg::data_type ga_out, gb_out;

   // Angles in the left half plane are folded by a half turn with the
   // vector negated, so the iterations only see the right half plane.
   always_comb begin
      fold = ((in_phase + eea_pkg::QuarterTurn) & eea_pkg::HalfTurn) != '0;
      p_fold = fold ? (in_phase + eea_pkg::HalfTurn) : in_phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Last; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k <= Last; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= fold ? -in_a : in_a;
         y_ff[0]    <= fold ? -in_b : in_b;
         z_ff[0]    <= eea_pkg::PhaseW'(signed'(p_fold));
         byp_ff[0]  <= in_phase == '0;
         oa_ff[0]   <= in_a;
         ob_ff[0]   <= in_b;
         side_ff[0] <= in_side;
         for (int k = 1; k <= Last; k++) begin
            byp_ff[k]  <= byp_ff[k-1];
            oa_ff[k]   <= oa_ff[k-1];
            ob_ff[k]   <= ob_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         for (int i = 0; i < STAGES; i++) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - eea_pkg::PhaseW'(eea_pkg::AtanTab[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + eea_pkg::PhaseW'(eea_pkg::AtanTab[i]);
            end
         end
      end
   end

   eea_gain #(.KQ(KQ)) u_gain_a (
      .clock(clock), .en(en), .in_v(x_ff[STAGES]), .out_v(ga_out)
   );
   eea_gain #(.KQ(KQ)) u_gain_b (
      .clock(clock), .en(en), .in_v(y_ff[STAGES]), .out_v(gb_out)
   );

   assign out_valid = v_ff[Last];
   assign out_a     = byp_ff[Last] ? oa_ff[Last] : ga_out;
   assign out_b     = byp_ff[Last] ? ob_ff[Last] : gb_out;
   assign out_side  = side_ff[Last];
endmodule

### hw/rtl/eea_vec.sv
module eea_vec #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  eea_pkg::data_type  in_x,
   input  eea_pkg::data_type  in_y,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output eea_pkg::data_type  out_x,
   output eea_pkg::phase_type out_acc,
   output logic [SIDE_W-1:0]  out_side
);
   logic               v_ff    [0:STAGES];
   logic [SIDE_W-1:0]  side_ff [0:STAGES];
   eea_pkg::data_type  x_ff    [0:STAGES];
   eea_pkg::data_type  y_ff    [0:STAGES];
   eea_pkg::phase_type acc_ff  [0:STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STAGES; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k <= STAGES; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // Each stage drives y toward zero and accumulates the angle it turned.
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= in_x[eea_pkg::DataW-1] ? -in_x : in_x;
         y_ff[0]    <= in_x[eea_pkg::DataW-1] ? -in_y : in_y;
         acc_ff[0]  <= '0;
         side_ff[0] <= in_side;
         for (int k = 1; k <= STAGES; k++) side_ff[k] <= side_ff[k-1];
         for (int i = 0; i < STAGES; i++) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1]   <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] - (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] + eea_pkg::PhaseW'(eea_pkg::AtanTab[i]);
            end else begin
               x_ff[i+1]   <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] + (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] - eea_pkg::PhaseW'(eea_pkg::AtanTab[i]);
            end
         end
      end
   end

   assign out_valid = v_ff[STAGES];
   assign out_x     = x_ff[STAGES];
   assign out_acc   = acc_ff[STAGES];
   assign out_side  = side_ff[STAGES];
endmodule

### hw/rtl/exit_elevation_angle.sv
// A request passes four rotations, a magnitude and an angle CORDIC in a row to its
// response. Throughput: one item per cycle unless the response stalls; every CORDIC
// iteration has its own register stage.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
// Reset is synchronous: it clears all valid bits and both angle registers to zero.
module exit_elevation_angle #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   eea_req_if.sink               req_chan,
   eea_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [ANGLE_BITS-1:0] csr_write_data
);
   localparam int Kq = eea_pkg::gain_kq(CORDIC_STAGES);
   localparam int Sh = eea_pkg::TurnW - ANGLE_BITS;
   localparam int RndW = eea_pkg::PhaseW + 1;
   localparam logic signed [RndW-1:0] Lim = RndW'(1) <<< (ANGLE_BITS - 2);
   localparam logic signed [RndW-1:0] Half = RndW'(1) <<< (Sh - 1);

   logic en;
   logic [ANGLE_BITS-1:0] incidence_ff, tilt_ff;
   logic rsp_valid_ff;
   logic signed [ANGLE_BITS-1:0] exit_ff, exit_in;

   logic              r1_v, r2_v, r3_v, r4_v, m_v, e_v;
   eea_pkg::data_type r1_a, r1_b, r2_a, r2_b, r2_s, r3_a, r3_b, r3_s;
   eea_pkg::data_type r4_a, r4_b, r4_s, m_x, m_z, r_mag;
   logic [ANGLE_BITS-1:0] r1_s;
   eea_pkg::phase_type e_acc;
   logic [0:0] e_zero;
   logic       mg_v_ff [0:1];
   eea_pkg::data_type mg_z_ff [0:1];
   logic signed [RndW-1:0] rnd, res;

   function automatic eea_pkg::turn_type to_turn(input logic [ANGLE_BITS-1:0] c);
      return {c, {Sh{1'b0}}};
   endfunction

   assign en = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         incidence_ff <= '0;
         tilt_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (eea_pkg::csr_index_type'(csr_index))
            eea_pkg::REG_INCIDENCE: incidence_ff <= csr_write_data;
            eea_pkg::REG_TILT:      tilt_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Unit vector from the polar angle: (sin t, cos t) in the (x, z) pair.
   eea_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(ANGLE_BITS), .KQ(Kq)) u_rot_polar (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_chan.valid), .in_a(eea_pkg::OneQ30), .in_b('0),
      .in_phase(to_turn(req_chan.polar_angle)), .in_side(req_chan.azimuth_angle),
      .out_valid(r1_v), .out_a(r1_a), .out_b(r1_b), .out_side(r1_s)
   );

   eea_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(eea_pkg::DataW), .KQ(Kq)) u_rot_azim (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(r1_v), .in_a(r1_b), .in_b('0),
      .in_phase(to_turn(r1_s)), .in_side(r1_a),
      .out_valid(r2_v), .out_a(r2_a), .out_b(r2_b), .out_side(r2_s)
   );

   eea_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(eea_pkg::DataW), .KQ(Kq)) u_rot_incid (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(r2_v), .in_a(r2_a), .in_b(r2_s),
      .in_phase(eea_pkg::QuarterTurn + to_turn(incidence_ff)), .in_side(r2_b),
      .out_valid(r3_v), .out_a(r3_a), .out_b(r3_b), .out_side(r3_s)
   );

   eea_rot #(.STAGES(CORDIC_STAGES), .SIDE_W(eea_pkg::DataW), .KQ(Kq)) u_rot_tilt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(r3_v), .in_a(r3_b), .in_b(r3_s),
      .in_phase(to_turn(tilt_ff)), .in_side(r3_a),
      .out_valid(r4_v), .out_a(r4_a), .out_b(r4_b), .out_side(r4_s)
   );

   // Magnitude of (x, y); z rides along.
   eea_vec #(.STAGES(CORDIC_STAGES), .SIDE_W(eea_pkg::DataW)) u_vec_mag (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(r4_v), .in_x(r4_s), .in_y(r4_b), .in_side(r4_a),
      .out_valid(m_v), .out_x(m_x), .out_acc(), .out_side(m_z)
   );

   eea_gain #(.KQ(Kq)) u_gain_mag (
      .clock(clock), .en(en), .in_v(m_x), .out_v(r_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mg_v_ff[0] <= 1'b0;
         mg_v_ff[1] <= 1'b0;
      end else if (en) begin
         mg_v_ff[0] <= m_v;
         mg_v_ff[1] <= mg_v_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mg_z_ff[0] <= m_z;
         mg_z_ff[1] <= mg_z_ff[0];
      end
   end

   eea_vec #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_vec_elev (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(mg_v_ff[1]), .in_x(r_mag), .in_y(mg_z_ff[1]),
      .in_side((r_mag == '0) && (mg_z_ff[1] == '0)),
      .out_valid(e_v), .out_x(), .out_acc(e_acc), .out_side(e_zero)
   );

   always_comb begin
      rnd = RndW'(e_acc) + Half;
      res = rnd >>> Sh;
      if (e_zero[0]) begin
         exit_in = '0;
      end else if (res > Lim) begin
         exit_in = ANGLE_BITS'(Lim);
      end else if (res < -Lim) begin
         exit_in = ANGLE_BITS'(-Lim);
      end else begin
         exit_in = ANGLE_BITS'(res);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= e_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exit_ff <= exit_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.exit_angle = exit_ff;

   a_exit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (exit_ff <= ANGLE_BITS'(Lim)) && (exit_ff >= ANGLE_BITS'(-Lim)))
      else $error("exit angle beyond a quarter turn");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      en && e_v && e_zero[0] |=> rsp_valid_ff && (exit_ff == '0))
      else $error("zero vector did not give a zero angle");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(r4_v) && $stable(e_v) && $stable(mg_v_ff[1]))
      else $error("pipeline moved during a stall");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while the response is stalled");
endmodule

### sim/exit_elevation_angle_test.sv
module exit_elevation_angle_test;

   localparam int AngleBits  = 16;
   localparam int StageCount = 16;
   localparam int Latency    = 6 * StageCount + 17;
   localparam int RandomItems = 450;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = eea_pkg::REG_INCIDENCE;
   logic [AngleBits-1:0] csr_write_data = '0;

   eea_req_if #(.ANGLE_BITS(AngleBits)) req_chan ();
   eea_rsp_if #(.ANGLE_BITS(AngleBits)) rsp_chan ();

   exit_elevation_angle #(.ANGLE_BITS(AngleBits), .CORDIC_STAGES(StageCount)) uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   typedef struct {
      logic [15:0] polar;
      logic [15:0] azimuth;
      bit          known;
      logic [15:0] angle;
   } direction_type;

   logic [15:0] incidence_reg = '0;
   logic [15:0] tilt_reg = '0;
   logic signed [15:0] pending_angles[$];
   int error_count = 0;
   int result_count = 0;
   bit rsp_idle_enable = 1'b1;
   bit req_idle_enable = 1'b1;
   bit long_hold = 1'b0;

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint apply_gain(longint v);
      longint kq;
      int n2;
      n2 = 2 * StageCount;
      kq = 64'd652032874 + ((64'd434688583 + (64'd1 << (n2 - 1))) >> n2);
      return shift_floor(v * kq + (64'sd1 <<< 29), 30);
   endfunction

   function automatic logic [31:0] code_phase(logic [15:0] code);
      return {code, 16'h0000};
   endfunction

   function automatic void turn_pair(inout longint a, inout longint b,
                                     input logic [31:0] p);
      longint x, y, z, xs, ys;
      x = a;
      y = b;
      if (p == 32'd0) return;
      if (((p + eea_pkg::QuarterTurn) & eea_pkg::HalfTurn) != 0) begin
         x = -x;
         y = -y;
         p = p + eea_pkg::HalfTurn;
      end
      z = p[31] ? longint'(p) - 64'sd4294967296 : longint'(p);
      for (int i = 0; i < StageCount; i++) begin
         xs = shift_floor(x, i);
         ys = shift_floor(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= eea_pkg::AtanTab[i];
         end else begin
            x += ys; y -= xs; z += eea_pkg::AtanTab[i];
         end
      end
      a = apply_gain(x);
      b = apply_gain(y);
   endfunction

   function automatic logic signed [15:0] predict_exit_angle(logic [15:0] polar,
                                                             logic [15:0] azimuth);
      longint cz, sz, x, y, z, r, acc, xs, ys, res, lim;
      cz = eea_pkg::OneQ30;
      sz = 0;
      y = 0;
      turn_pair(cz, sz, code_phase(polar));
      x = sz;
      z = cz;
      turn_pair(x, y, code_phase(azimuth));
      turn_pair(x, z, eea_pkg::QuarterTurn + code_phase(incidence_reg));
      turn_pair(z, y, code_phase(tilt_reg));
      // Magnitude of (x, y) in vectoring mode.
      if (x < 0) begin
         x = -x; y = -y;
      end
      for (int i = 0; i < StageCount; i++) begin
         xs = shift_floor(x, i);
         ys = shift_floor(y, i);
         if (y >= 0) begin
            x += ys; y -= xs;
         end else begin
            x -= ys; y += xs;
         end
      end
      r = apply_gain(x);
      if (r == 0 && z == 0) return 16'sd0;
      acc = 0;
      for (int i = 0; i < StageCount; i++) begin
         xs = shift_floor(r, i);
         ys = shift_floor(z, i);
         if (z >= 0) begin
            r += ys; z -= xs; acc += eea_pkg::AtanTab[i];
         end else begin
            r -= ys; z += xs; acc -= eea_pkg::AtanTab[i];
         end
      end
      res = shift_floor(acc + (64'sd1 <<< 15), 16);
      lim = 64'sd1 <<< (AngleBits - 2);
      if (res > lim) res = lim;
      if (res < -lim) res = -lim;
      return res[15:0];
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // The write enable is left high; the caller drops it after its last write.
   task automatic write_register(input eea_pkg::csr_index_type index,
                                 input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      if (index == eea_pkg::REG_INCIDENCE) incidence_reg = value;
      else tilt_reg = value;
   endtask

   task automatic send_direction(input logic [15:0] polar, input logic [15:0] azimuth,
                                 input bit known, input logic [15:0] angle);
      int gap;
      logic signed [15:0] want;
      if (req_idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.polar_angle <= polar;
      req_chan.azimuth_angle <= azimuth;
      do @(posedge clock); while (!req_chan.ready);
      if (known && angle !== predict_exit_angle(polar, azimuth))
         report_mismatch("directed row", predict_exit_angle(polar, azimuth), angle);
      want = known ? angle : predict_exit_angle(polar, azimuth);
      pending_angles.insert(pending_angles.size(), want);
   endtask

   task automatic drain_results;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   // Receiver: random stall bursts, plus one long hold-off to back up the pipeline.
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            if (pending_angles.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_chan.exit_angle, 0);
            end else begin
               want = pending_angles.pop_front();
               if (rsp_chan.exit_angle !== want)
                  report_mismatch("exit_angle", rsp_chan.exit_angle, want);
            end
         end
         rsp_chan.ready <= !long_hold && !(rsp_idle_enable && $urandom_range(0, 4) == 0);
      end
   end

   initial begin
      // Directed directions with reset registers, among them straight up, along the beam and straight down.
      direction_type rows [12] = '{
         '{16'h0000, 16'h0000, 1'b0, 16'h0},
         '{16'h8000, 16'h0000, 1'b0, 16'h0},
         '{16'h4000, 16'h0000, 1'b0, 16'h0},
         '{16'h4000, 16'h8000, 1'b0, 16'h0},
         '{16'h4000, 16'h4000, 1'b0, 16'h0},
         '{16'h4000, 16'hC000, 1'b0, 16'h0},
         '{16'hFFFF, 16'hFFFF, 1'b0, 16'h0},
         '{16'h8001, 16'h0001, 1'b0, 16'h0},
         '{16'h2000, 16'h2000, 1'b0, 16'h0},
         '{16'hC000, 16'h5555, 1'b0, 16'h0},
         '{16'hAAAA, 16'h5555, 1'b0, 16'h0},
         '{16'h5555, 16'hAAAA, 1'b0, 16'h0}
      };
      logic [15:0] polar, azimuth;
      logic [15:0] settings[4][2] = '{'{16'h0000, 16'h0000}, '{16'h7FFF, 16'h8000},
                                      '{16'h8000, 16'h7FFF}, '{16'h1234, 16'hF000}};

      req_chan.valid = 1'b0;
      req_chan.polar_angle = '0;
      req_chan.azimuth_angle = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_direction(rows[i].polar, rows[i].azimuth, rows[i].known,
                                        rows[i].angle);
      drain_results();

      for (int s = 0; s < 4; s++) begin
         write_register(eea_pkg::REG_INCIDENCE, settings[s][0]);
         write_register(eea_pkg::REG_TILT, settings[s][1]);
         csr_write_enable <= 1'b0;
         if (s == 2) begin
            fork
               begin
                  long_hold = 1'b1;
                  repeat (Latency + 60) @(posedge clock);
                  long_hold = 1'b0;
               end
            join_none
         end
         if (s == 3) begin
            req_idle_enable = 1'b0;
            rsp_idle_enable = 1'b0;
         end
         for (int i = 0; i < RandomItems / 4; i++) begin
            polar = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
            azimuth = 16'($urandom);
            send_direction(polar, azimuth, 1'b0, 16'h0);
         end
         drain_results();
      end

      $display("Covered %0d results over 5 register settings with both extremes,", result_count);
      $display("directed poles and axes, random directions and a long response stall.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
